@@ design/rc4_stream_cipher_assert.svh @@
// Assertion macros used by the RC4 cipher module.
`ifndef RC4_STREAM_CIPHER_ASSERT_SVH
`define RC4_STREAM_CIPHER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RC4_ASSERT_NOW(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RC4_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

@@ design/rc4_pkg.sv @@
// Types and constants for the RC4 stream cipher.
`timescale 1ns / 1ps

package rc4_pkg;

    localparam int TABLE_SIZE     = 256;
    localparam int MAX_KEY_LENGTH = 256;
    localparam int BYTE_W         = 8;
    localparam int CFG_W          = 9;
    localparam int OP_W           = 2;

    localparam logic [CFG_W-1:0] KEY_LENGTH_RESET     = 9'd16;
    localparam logic [CFG_W-1:0] SCHEDULE_STEPS_RESET = 9'd256;

    typedef enum logic [OP_W-1:0] {
        OP_KEY_WRITE = 2'd0,
        OP_SCHEDULE  = 2'd1,
        OP_CIPHER    = 2'd2
    } op_t;

    typedef enum logic [0:0] {
        CFG_KEY_LENGTH     = 1'b0,
        CFG_SCHEDULE_STEPS = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_D_RJ,
        ST_D_WI,
        ST_D_OUT,
        ST_S_RK,
        ST_S_RJ,
        ST_S_WK,
        ST_S_WJ
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [BYTE_W-1:0] key_index;
        logic [BYTE_W-1:0] key_byte;
        logic [BYTE_W-1:0] data_byte;
        logic              message_start;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              is_data;
    } out_item_t;

endpackage

@@ design/rc4_stream_cipher.sv @@
// RC4 stream cipher: permutation table and key store in synchronous RAMs.
// Cipher byte: reads S[i], then S[j], then S[S[i]+S[j]]; the result shows in ST_D_OUT, and
//   the next item may start in that result cycle.
// Key write or unused code: result in the next cycle, one item per cycle while not busy.
// Key schedule: each step reads S[k] and the key byte, reads S[j], writes S[k] and S[j] (no swap when steps is 0).
// Reset: table reads as identity at once (per-entry valid bits), i=j=0, key_length 16,
//   schedule_steps 256; key store contents undefined until written.
`timescale 1ns / 1ps
`include "rc4_stream_cipher_assert.svh"

module rc4_stream_cipher
    import rc4_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  in_item_t             item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  cfg_index_t           cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic                 result_valid,
    output out_item_t            result
);

    // configuration
    logic [CFG_W-1:0] key_length_reg;
    logic [CFG_W-1:0] schedule_steps_reg;
    logic [CFG_W-1:0] len_eff;
    logic [CFG_W-1:0] steps_eff;

    // control and stream state
    state_t            state_reg, state_next;
    logic [BYTE_W-1:0] i_reg, i_next;
    logic [BYTE_W-1:0] j_reg, j_next;
    logic [BYTE_W-1:0] k_reg, k_next;
    logic [BYTE_W-1:0] kpos_reg, kpos_next;
    logic [BYTE_W-1:0] si_reg, si_next;
    logic [BYTE_W-1:0] t_reg, t_next;
    logic [BYTE_W-1:0] data_reg, data_next;
    logic              simple_valid_reg, simple_valid_next;

    // table RAM
    logic [BYTE_W-1:0] perm_mem_reg [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] valid_reg;
    logic [BYTE_W-1:0] perm_q_reg;
    logic [BYTE_W-1:0] byp_data_reg;
    logic [BYTE_W-1:0] raddr_q_reg;
    logic              byp_hit_reg;
    logic              vld_hit_reg;
    logic              perm_we;
    logic [BYTE_W-1:0] perm_waddr;
    logic [BYTE_W-1:0] perm_wdata;
    logic [BYTE_W-1:0] perm_raddr;
    logic [BYTE_W-1:0] perm_rdata;
    logic              table_clear;

    // key RAM
    logic [BYTE_W-1:0] key_mem_reg [MAX_KEY_LENGTH];
    logic [BYTE_W-1:0] key_q_reg;
    logic              key_we;
    logic [BYTE_W-1:0] key_raddr;

    // helpers
    logic              accept;
    logic [BYTE_W-1:0] i_new;
    logic [BYTE_W-1:0] j_base;
    logic [BYTE_W-1:0] sched_j;
    logic [BYTE_W-1:0] swap_sum;
    logic [CFG_W-1:0]  kpos_wide;
    logic [CFG_W-1:0]  kpos_inc;
    logic [BYTE_W-1:0] kpos_adv;
    logic [CFG_W-1:0]  k_inc;
    logic              last_step;
    logic [BYTE_W-1:0] ks_byte;

    assign cfg_ready = 1'b1;
    assign busy      = (state_reg != ST_IDLE) && (state_reg != ST_D_OUT);
    assign accept    = start && !busy;

    always_comb
    begin
        if (key_length_reg == '0)
        begin
            len_eff = 9'd1;
        end
        else if (key_length_reg > CFG_W'(MAX_KEY_LENGTH))
        begin
            len_eff = CFG_W'(MAX_KEY_LENGTH);
        end
        else
        begin
            len_eff = key_length_reg;
        end
        if (schedule_steps_reg > CFG_W'(TABLE_SIZE))
        begin
            steps_eff = CFG_W'(TABLE_SIZE);
        end
        else
        begin
            steps_eff = schedule_steps_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg     <= KEY_LENGTH_RESET;
            schedule_steps_reg <= SCHEDULE_STEPS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_KEY_LENGTH:     key_length_reg     <= cfg_data;
                CFG_SCHEDULE_STEPS: schedule_steps_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Table read data: same-edge write wins, unwritten entries read as identity.
    assign perm_rdata = byp_hit_reg ? byp_data_reg : (vld_hit_reg ? perm_q_reg : raddr_q_reg);

    assign i_new     = (item.message_start ? 8'd0 : i_reg) + 8'd1;
    assign j_base    = item.message_start ? 8'd0 : j_reg;
    assign sched_j   = j_reg + perm_rdata + key_q_reg;
    assign swap_sum  = si_reg + perm_rdata;
    assign kpos_wide = {1'b0, kpos_reg};
    assign kpos_inc  = kpos_wide + 9'd1;
    assign kpos_adv  = (kpos_inc >= len_eff) ? 8'd0 : kpos_inc[BYTE_W-1:0];
    assign k_inc     = {1'b0, k_reg} + 9'd1;
    assign last_step = (k_inc == steps_eff);
    // S[t] was read before S[j] got its swapped value
    assign ks_byte   = (t_reg == j_reg) ? si_reg : perm_rdata;

    always_comb
    begin
        state_next        = state_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        k_next            = k_reg;
        kpos_next         = kpos_reg;
        si_next           = si_reg;
        t_next            = t_reg;
        data_next         = data_reg;
        simple_valid_next = 1'b0;
        perm_we           = 1'b0;
        perm_waddr        = i_reg;
        perm_wdata        = perm_rdata;
        perm_raddr        = k_reg;
        table_clear       = 1'b0;
        key_we            = 1'b0;
        key_raddr         = kpos_reg;

        case (state_reg)
            ST_IDLE:
            begin
            end
            ST_D_RJ:
            begin
                si_next    = perm_rdata;
                j_next     = j_reg + perm_rdata;
                perm_raddr = j_reg + perm_rdata;
                state_next = ST_D_WI;
            end
            ST_D_WI:
            begin
                perm_we    = 1'b1;
                perm_waddr = i_reg;
                perm_wdata = perm_rdata;
                perm_raddr = swap_sum;
                t_next     = swap_sum;
                state_next = ST_D_OUT;
            end
            ST_D_OUT:
            begin
                perm_we    = 1'b1;
                perm_waddr = j_reg;
                perm_wdata = si_reg;
                state_next = ST_IDLE;
            end
            ST_S_RK:
            begin
                perm_raddr = k_reg;
                key_raddr  = kpos_reg;
                state_next = ST_S_RJ;
            end
            ST_S_RJ:
            begin
                si_next    = perm_rdata;
                j_next     = sched_j;
                perm_raddr = sched_j;
                state_next = ST_S_WK;
            end
            ST_S_WK:
            begin
                perm_we    = 1'b1;
                perm_waddr = k_reg;
                perm_wdata = perm_rdata;
                state_next = ST_S_WJ;
            end
            ST_S_WJ:
            begin
                perm_we    = 1'b1;
                perm_waddr = j_reg;
                perm_wdata = si_reg;
                if (last_step)
                begin
                    i_next            = 8'd0;
                    j_next            = 8'd0;
                    simple_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
                else
                begin
                    k_next     = k_inc[BYTE_W-1:0];
                    kpos_next  = kpos_adv;
                    perm_raddr = k_inc[BYTE_W-1:0];
                    key_raddr  = kpos_adv;
                    state_next = ST_S_RJ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (accept)
        begin
            case (op_t'(item.operation))
                OP_KEY_WRITE:
                begin
                    key_we            = 1'b1;
                    simple_valid_next = 1'b1;
                end
                OP_SCHEDULE:
                begin
                    table_clear = 1'b1;
                    i_next      = 8'd0;
                    j_next      = 8'd0;
                    k_next      = 8'd0;
                    kpos_next   = 8'd0;
                    if (steps_eff == '0)
                    begin
                        simple_valid_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_S_RK;
                    end
                end
                OP_CIPHER:
                begin
                    i_next     = i_new;
                    j_next     = j_base;
                    data_next  = item.data_byte;
                    perm_raddr = i_new;
                    state_next = ST_D_RJ;
                end
                default:
                begin
                    simple_valid_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            i_reg            <= '0;
            j_reg            <= '0;
            k_reg            <= '0;
            kpos_reg         <= '0;
            simple_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            k_reg            <= k_next;
            kpos_reg         <= kpos_next;
            simple_valid_reg <= simple_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        si_reg   <= si_next;
        t_reg    <= t_next;
        data_reg <= data_next;
    end

    // table RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (perm_we)
        begin
            perm_mem_reg[perm_waddr] <= perm_wdata;
        end
        perm_q_reg   <= perm_mem_reg[perm_raddr];
        byp_data_reg <= perm_wdata;
        raddr_q_reg  <= perm_raddr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            byp_hit_reg <= 1'b0;
            vld_hit_reg <= 1'b0;
        end
        else
        begin
            byp_hit_reg <= perm_we && (perm_waddr == perm_raddr);
            vld_hit_reg <= valid_reg[perm_raddr];
            if (table_clear)
            begin
                valid_reg <= '0;
            end
            else if (perm_we)
            begin
                valid_reg[perm_waddr] <= 1'b1;
            end
        end
    end

    // key RAM
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem_reg[item.key_index] <= item.key_byte;
        end
        key_q_reg <= key_mem_reg[key_raddr];
    end

    assign result_valid    = (state_reg == ST_D_OUT) || simple_valid_reg;
    assign result.is_data  = (state_reg == ST_D_OUT);
    assign result.out_byte = (state_reg == ST_D_OUT) ? (data_reg ^ ks_byte) : 8'd0;

    `RC4_ASSERT_NOW(a_single_result_source, state_reg == ST_D_OUT, !simple_valid_reg,
        "cipher result collides with a pending simple result")
    `RC4_ASSERT_NEXT(a_cipher_enters_pipe, accept && (item.operation == OP_CIPHER),
        (state_reg == ST_D_RJ) && (perm_raddr == j_reg + perm_rdata),
        "cipher transfer did not start the table read sequence")
    `RC4_ASSERT_NOW(a_kpos_in_range, (state_reg == ST_S_RJ) || (state_reg == ST_S_WJ),
        kpos_wide < len_eff, "key position ran past the key length")
    `RC4_ASSERT_NOW(a_swap_write_j, state_reg == ST_D_OUT,
        perm_we && (perm_waddr == j_reg) && (perm_wdata == si_reg),
        "second swap write missing in result cycle")

endmodule
